// ----- design/dyp_pkg.sv -----
// Shared types, widths and constants for the direction to yaw/pitch block.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package dyp_pkg;

    // Input component width (signed Q16.16) and output angle field width.
    localparam int IN_W  = 32;
    localparam int OUT_W = 16;

    // Internal datapath width for vectors and the square root operand.
    localparam int DATA_W = 64;

    // Binary angle accumulator width: 2^ACC_W is one full turn.
    localparam int ACC_W = 32;

    // Components are scaled by 2^FRAC_SHIFT before the CORDIC.
    localparam int FRAC_SHIFT = 24;

    // Width of the normalization count (0 to 16 pairs of bits).
    localparam int S_W = 5;

    // Number of normalization cells and of square root cells.
    localparam int NORM_STEPS = 5;
    localparam int SQRT_STEPS = 32;

    // Fixed binary angles.
    localparam logic [ACC_W-1:0] ANG_ZERO     = 32'h0000_0000;
    localparam logic [ACC_W-1:0] ANG_PI       = 32'h8000_0000;
    localparam logic [ACC_W-1:0] ANG_UP       = 32'h4000_0000;
    localparam logic [ACC_W-1:0] ANG_DOWN     = 32'hC000_0000;

    // Arctangent of 2^-i as a binary angle, for CORDIC stage i.
    localparam logic [ACC_W-1:0] ATAN_TABLE [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    // Degenerate input classes.
    typedef enum logic [1:0] {
        DEG_NONE = 2'd0,
        DEG_AXIS = 2'd1,
        DEG_ZERO = 2'd2
    } deg_t;

    // Item fields that ride along the front end, up to the square root output.
    typedef struct packed {
        logic [IN_W-1:0] x;
        logic [IN_W-1:0] y;
        logic [IN_W-1:0] z;
        deg_t            deg;
    } front_t;

    // Item fields that ride along the CORDIC rows.
    typedef struct packed {
        deg_t deg;
        logic z_neg;
    } back_t;

    // Pairs of bits that normalization cell number step may shift by.
    function automatic int norm_pairs(input int step);
        int pairs;
        pairs = (step < 4) ? (8 >> step) : 1;
        return pairs;
    endfunction

endpackage

`default_nettype wire

// ----- design/dyp_norm_cell.sv -----
// One normalization cell: shifts the squared length left by a fixed number of
// bit pairs when the top bits leave room. Depends on dyp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dyp_norm_cell #(
    parameter int PAIRS = 1
) (
    input  wire logic                         clk,
    input  wire logic [dyp_pkg::DATA_W-1:0]   v_in,
    input  wire logic [dyp_pkg::S_W-1:0]      s_in,
    output logic      [dyp_pkg::DATA_W-1:0]   v_out,
    output logic      [dyp_pkg::S_W-1:0]      s_out
);

    localparam int TOP_BITS = 2 + 2 * PAIRS;

    logic                         room;
    logic [dyp_pkg::DATA_W-1:0]   v_next;
    logic [dyp_pkg::S_W-1:0]      s_next;
    logic [dyp_pkg::DATA_W-1:0]   v_reg;
    logic [dyp_pkg::S_W-1:0]      s_reg;

    // The shift is taken only if the top two bits stay clear afterwards.
    always_comb
    begin
        room = (v_in[dyp_pkg::DATA_W-1 -: TOP_BITS] == '0);
        if (room)
        begin
            v_next = v_in << (2 * PAIRS);
            s_next = s_in + dyp_pkg::S_W'(PAIRS);
        end
        else
        begin
            v_next = v_in;
            s_next = s_in;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg <= v_next;
        s_reg <= s_next;
    end

    assign v_out = v_reg;
    assign s_out = s_reg;

endmodule

`default_nettype wire

// ----- design/dyp_sqrt_cell.sv -----
// One digit of the bit-by-bit integer square root of a 64-bit operand.
// Depends on dyp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dyp_sqrt_cell #(
    parameter int STEP = 0
) (
    input  wire logic                         clk,
    input  wire logic [dyp_pkg::DATA_W-1:0]   n_in,
    input  wire logic [dyp_pkg::DATA_W-1:0]   res_in,
    input  wire logic [dyp_pkg::S_W-1:0]      s_in,
    output logic      [dyp_pkg::DATA_W-1:0]   n_out,
    output logic      [dyp_pkg::DATA_W-1:0]   res_out,
    output logic      [dyp_pkg::S_W-1:0]      s_out
);

    localparam logic [dyp_pkg::DATA_W-1:0] BIT_VAL =
        dyp_pkg::DATA_W'(1) << (dyp_pkg::DATA_W - 2 - 2 * STEP);

    logic [dyp_pkg::DATA_W-1:0] trial;
    logic [dyp_pkg::DATA_W-1:0] n_next;
    logic [dyp_pkg::DATA_W-1:0] res_next;
    logic [dyp_pkg::DATA_W-1:0] n_reg;
    logic [dyp_pkg::DATA_W-1:0] res_reg;
    logic [dyp_pkg::S_W-1:0]    s_reg;

    // Try to set this root bit; keep the remainder if it fits.
    always_comb
    begin
        trial = res_in + BIT_VAL;
        if (n_in >= trial)
        begin
            n_next   = n_in - trial;
            res_next = (res_in >> 1) + BIT_VAL;
        end
        else
        begin
            n_next   = n_in;
            res_next = res_in >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg   <= n_next;
        res_reg <= res_next;
        s_reg   <= s_in;
    end

    assign n_out   = n_reg;
    assign res_out = res_reg;
    assign s_out   = s_reg;

endmodule

`default_nettype wire

// ----- design/dyp_cordic_cell.sv -----
// One vectoring CORDIC micro-rotation that drives y toward zero and collects
// the turned angle. Depends on dyp_pkg for widths and the arctangent table.
`timescale 1ns / 1ps
`default_nettype none

module dyp_cordic_cell #(
    parameter int STAGE = 0
) (
    input  wire logic                                clk,
    input  wire logic signed [dyp_pkg::DATA_W-1:0]   x_in,
    input  wire logic signed [dyp_pkg::DATA_W-1:0]   y_in,
    input  wire logic        [dyp_pkg::ACC_W-1:0]    ang_in,
    output logic signed      [dyp_pkg::DATA_W-1:0]   x_out,
    output logic signed      [dyp_pkg::DATA_W-1:0]   y_out,
    output logic             [dyp_pkg::ACC_W-1:0]    ang_out
);

    localparam logic [dyp_pkg::ACC_W-1:0] ATAN_STEP = dyp_pkg::ATAN_TABLE[STAGE];

    logic signed [dyp_pkg::DATA_W-1:0] dx;
    logic signed [dyp_pkg::DATA_W-1:0] dy;
    logic signed [dyp_pkg::DATA_W-1:0] x_next;
    logic signed [dyp_pkg::DATA_W-1:0] y_next;
    logic        [dyp_pkg::ACC_W-1:0]  ang_next;
    logic signed [dyp_pkg::DATA_W-1:0] x_reg;
    logic signed [dyp_pkg::DATA_W-1:0] y_reg;
    logic        [dyp_pkg::ACC_W-1:0]  ang_reg;

    // Rotate toward the x axis in the direction set by the sign of y.
    always_comb
    begin
        dx = x_in >>> STAGE;
        dy = y_in >>> STAGE;
        if (y_in[dyp_pkg::DATA_W-1])
        begin
            x_next   = x_in - dy;
            y_next   = y_in + dx;
            ang_next = ang_in - ATAN_STEP;
        end
        else
        begin
            x_next   = x_in + dy;
            y_next   = y_in - dx;
            ang_next = ang_in + ATAN_STEP;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        y_reg   <= y_next;
        ang_reg <= ang_next;
    end

    assign x_out   = x_reg;
    assign y_out   = y_reg;
    assign ang_out = ang_reg;

endmodule

`default_nettype wire

// ----- design/direction_to_yaw_pitch_top.sv -----
// Top level of the direction to yaw/pitch block: squares, normalization and
// square root chains, two CORDIC rows and the rounding stage.
// Depends on dyp_pkg, dyp_norm_cell, dyp_sqrt_cell and dyp_cordic_cell.
//
// Usage:
//   Input channel: drive dir_x, dir_y, dir_z (signed Q16.16) and pulse start.
//   An item is taken at every rising edge where start is high and busy is low.
//   busy stays low, so a new item may be offered in every cycle.
//   Output channel: done is high for exactly one cycle with yaw, pitch and
//   degenerate valid in that cycle; the receiver takes it then and cannot
//   hold it off, so results flow out at the same rate items flowed in.
//   Path of an item: input register, squares, sum, 5 normalization
//   cells, 32 square root cells, CORDIC setup, one CORDIC cell per
//   stage, then rounding.
//   Throughput: one item per cycle, since every cell is a pipeline stage.
//   Reset (rst_n low) clears all valid flags at once; items in flight are
//   dropped and done stays low until new items arrive.
`timescale 1ns / 1ps
`default_nettype none

module direction_to_yaw_pitch_top #(
    parameter int CORDIC_STAGES = 16,
    parameter int ANGLE_BITS    = 16
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic signed [dyp_pkg::IN_W-1:0]    dir_x,
    input  wire logic signed [dyp_pkg::IN_W-1:0]    dir_y,
    input  wire logic signed [dyp_pkg::IN_W-1:0]    dir_z,
    output logic                                    done,
    output logic signed      [dyp_pkg::OUT_W-1:0]   yaw,
    output logic signed      [dyp_pkg::OUT_W-1:0]   pitch,
    output logic             [1:0]                  degenerate
);

    localparam int NUM        = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
    localparam int FRONT_LAST = 2 + dyp_pkg::NORM_STEPS + dyp_pkg::SQRT_STEPS;
    localparam int LAST       = FRONT_LAST + 2 + NUM;
    localparam int LATENCY    = LAST + 1;
    localparam int SH         = (ANGLE_BITS >= 32) ? 0 : 32 - ANGLE_BITS;
    localparam logic [dyp_pkg::ACC_W-1:0] HALF = (32'd1 << SH) >> 1;

    localparam int DW = dyp_pkg::DATA_W;
    localparam int IW = dyp_pkg::IN_W;
    localparam int AW = dyp_pkg::ACC_W;

    // Valid flags for every pipeline stage; the last one is done.
    logic vld_reg  [0:LAST];
    logic accept;

    // Item fields travelling beside the datapath.
    dyp_pkg::front_t fs_reg [0:FRONT_LAST];
    dyp_pkg::front_t fs_next;
    dyp_pkg::back_t  bs_reg [0:NUM];
    dyp_pkg::back_t  bs_next;

    // Squares and sum of squares.
    logic [IW-1:0] ax;
    logic [IW-1:0] ay;
    logic [DW-1:0] sqx_reg;
    logic [DW-1:0] sqy_reg;
    logic [DW-1:0] sum_reg;

    // Normalization and square root chains.
    logic [DW-1:0]           norm_v   [0:dyp_pkg::NORM_STEPS];
    logic [dyp_pkg::S_W-1:0] norm_s   [0:dyp_pkg::NORM_STEPS];
    logic [DW-1:0]           sqrt_n   [0:dyp_pkg::SQRT_STEPS];
    logic [DW-1:0]           sqrt_res [0:dyp_pkg::SQRT_STEPS];
    logic [dyp_pkg::S_W-1:0] sqrt_s   [0:dyp_pkg::SQRT_STEPS];

    // CORDIC setup.
    logic signed [DW-1:0] x_wide;
    logic signed [DW-1:0] y_wide;
    logic signed [DW-1:0] xs_raw;
    logic signed [DW-1:0] ys_raw;
    logic                 flip;
    logic signed [DW-1:0] yx_next;
    logic signed [DW-1:0] yy_next;
    logic        [AW-1:0] ya_next;
    logic signed [DW-1:0] px_next;
    logic signed [DW-1:0] py_next;

    // CORDIC rows.
    logic signed [DW-1:0] yaw_x   [0:NUM];
    logic signed [DW-1:0] yaw_y   [0:NUM];
    logic        [AW-1:0] yaw_a   [0:NUM];
    logic signed [DW-1:0] pit_x   [0:NUM];
    logic signed [DW-1:0] pit_y   [0:NUM];
    logic        [AW-1:0] pit_a   [0:NUM];
    logic signed [DW-1:0] yx_reg;
    logic signed [DW-1:0] yy_reg;
    logic        [AW-1:0] ya_reg;
    logic signed [DW-1:0] px_reg;
    logic signed [DW-1:0] py_reg;

    // Output stage.
    logic        [AW-1:0] yaw_fin;
    logic        [AW-1:0] pit_fin;
    logic signed [AW-1:0] yaw_sh;
    logic signed [AW-1:0] pit_sh;
    logic [dyp_pkg::OUT_W-1:0] yaw_reg;
    logic [dyp_pkg::OUT_W-1:0] pitch_reg;
    dyp_pkg::deg_t             deg_reg;

    // The pipeline never stalls.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Valid chain.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= LAST; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else
        begin
            vld_reg[0] <= accept;
            for (int i = 1; i <= LAST; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    // Classify the input and capture it.
    always_comb
    begin
        fs_next.x = dir_x;
        fs_next.y = dir_y;
        fs_next.z = dir_z;
        if (dir_x == '0 && dir_y == '0)
        begin
            fs_next.deg = (dir_z == '0) ? dyp_pkg::DEG_ZERO : dyp_pkg::DEG_AXIS;
        end
        else
        begin
            fs_next.deg = dyp_pkg::DEG_NONE;
        end
    end

    // Front sideband shift line.
    always_ff @(posedge clk)
    begin
        fs_reg[0] <= fs_next;
        for (int i = 1; i <= FRONT_LAST; i++)
        begin
            fs_reg[i] <= fs_reg[i-1];
        end
    end

    // Squares of the magnitudes, then their sum.
    always_comb
    begin
        ax = fs_reg[0].x[IW-1] ? IW'(-fs_reg[0].x) : fs_reg[0].x;
        ay = fs_reg[0].y[IW-1] ? IW'(-fs_reg[0].y) : fs_reg[0].y;
    end

    always_ff @(posedge clk)
    begin
        sqx_reg <= DW'(ax) * DW'(ax);
        sqy_reg <= DW'(ay) * DW'(ay);
        sum_reg <= sqx_reg + sqy_reg;
    end

    // Normalization chain: shifts of 8, 4, 2, 1 and 1 bit pairs.
    assign norm_v[0] = sum_reg;
    assign norm_s[0] = '0;

    for (genvar g = 0; g < dyp_pkg::NORM_STEPS; g++)
    begin : g_norm
        dyp_norm_cell #(
            .PAIRS (dyp_pkg::norm_pairs(g))
        ) u_norm (
            .clk   (clk),
            .v_in  (norm_v[g]),
            .s_in  (norm_s[g]),
            .v_out (norm_v[g+1]),
            .s_out (norm_s[g+1])
        );
    end

    // Square root chain, one root bit per cell.
    assign sqrt_n[0]   = norm_v[dyp_pkg::NORM_STEPS];
    assign sqrt_res[0] = '0;
    assign sqrt_s[0]   = norm_s[dyp_pkg::NORM_STEPS];

    for (genvar g = 0; g < dyp_pkg::SQRT_STEPS; g++)
    begin : g_sqrt
        dyp_sqrt_cell #(
            .STEP (g)
        ) u_sqrt (
            .clk     (clk),
            .n_in    (sqrt_n[g]),
            .res_in  (sqrt_res[g]),
            .s_in    (sqrt_s[g]),
            .n_out   (sqrt_n[g+1]),
            .res_out (sqrt_res[g+1]),
            .s_out   (sqrt_s[g+1])
        );
    end

    // CORDIC setup: scale components, fold the left half plane for yaw,
    // and undo the normalization of the horizontal length for pitch.
    always_comb
    begin
        x_wide = DW'(signed'(fs_reg[FRONT_LAST].x));
        y_wide = DW'(signed'(fs_reg[FRONT_LAST].y));
        xs_raw = x_wide <<< dyp_pkg::FRAC_SHIFT;
        ys_raw = (-y_wide) <<< dyp_pkg::FRAC_SHIFT;
        flip   = xs_raw[DW-1];
        yx_next = flip ? -xs_raw : xs_raw;
        yy_next = flip ? -ys_raw : ys_raw;
        ya_next = flip ? dyp_pkg::ANG_PI : dyp_pkg::ANG_ZERO;
        px_next = signed'(DW'(sqrt_res[dyp_pkg::SQRT_STEPS][IW-1:0])
                  << (dyp_pkg::S_W'(dyp_pkg::FRAC_SHIFT) - sqrt_s[dyp_pkg::SQRT_STEPS]));
        py_next = DW'(signed'(fs_reg[FRONT_LAST].z)) <<< dyp_pkg::FRAC_SHIFT;
        bs_next.deg   = fs_reg[FRONT_LAST].deg;
        bs_next.z_neg = fs_reg[FRONT_LAST].z[IW-1];
    end

    always_ff @(posedge clk)
    begin
        yx_reg    <= yx_next;
        yy_reg    <= yy_next;
        ya_reg    <= ya_next;
        px_reg    <= px_next;
        py_reg    <= py_next;
        bs_reg[0] <= bs_next;
        for (int i = 1; i <= NUM; i++)
        begin
            bs_reg[i] <= bs_reg[i-1];
        end
    end

    // Two CORDIC rows side by side, yaw and pitch.
    assign yaw_x[0] = yx_reg;
    assign yaw_y[0] = yy_reg;
    assign yaw_a[0] = ya_reg;
    assign pit_x[0] = px_reg;
    assign pit_y[0] = py_reg;
    assign pit_a[0] = dyp_pkg::ANG_ZERO;

    for (genvar g = 0; g < NUM; g++)
    begin : g_cordic
        dyp_cordic_cell #(
            .STAGE (g)
        ) u_yaw (
            .clk     (clk),
            .x_in    (yaw_x[g]),
            .y_in    (yaw_y[g]),
            .ang_in  (yaw_a[g]),
            .x_out   (yaw_x[g+1]),
            .y_out   (yaw_y[g+1]),
            .ang_out (yaw_a[g+1])
        );

        dyp_cordic_cell #(
            .STAGE (g)
        ) u_pitch (
            .clk     (clk),
            .x_in    (pit_x[g]),
            .y_in    (pit_y[g]),
            .ang_in  (pit_a[g]),
            .x_out   (pit_x[g+1]),
            .y_out   (pit_y[g+1]),
            .ang_out (pit_a[g+1])
        );
    end

    // Degenerate overrides, then round half up to ANGLE_BITS bits.
    always_comb
    begin
        unique case (bs_reg[NUM].deg)
            dyp_pkg::DEG_ZERO:
            begin
                yaw_fin = dyp_pkg::ANG_ZERO;
                pit_fin = dyp_pkg::ANG_ZERO;
            end
            dyp_pkg::DEG_AXIS:
            begin
                yaw_fin = dyp_pkg::ANG_ZERO;
                pit_fin = bs_reg[NUM].z_neg ? dyp_pkg::ANG_DOWN : dyp_pkg::ANG_UP;
            end
            default:
            begin
                yaw_fin = yaw_a[NUM];
                pit_fin = pit_a[NUM];
            end
        endcase
        yaw_sh = signed'(yaw_fin + HALF) >>> SH;
        pit_sh = signed'(pit_fin + HALF) >>> SH;
    end

    always_ff @(posedge clk)
    begin
        yaw_reg   <= yaw_sh[dyp_pkg::OUT_W-1:0];
        pitch_reg <= pit_sh[dyp_pkg::OUT_W-1:0];
        deg_reg   <= bs_reg[NUM].deg;
    end

    assign done       = vld_reg[LAST];
    assign yaw        = signed'(yaw_reg);
    assign pitch      = signed'(pitch_reg);
    assign degenerate = deg_reg;

    // Every accepted item comes out after the fixed pipeline latency.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LATENCY done)
        else $error("accepted item did not produce a result on time");

    // A zero vector reports both angles as zero.
    a_zero_vec: assert property (@(posedge clk) disable iff (!rst_n)
        (done && degenerate == dyp_pkg::DEG_ZERO) |-> (yaw == '0 && pitch == '0))
        else $error("zero vector gave nonzero angles");

    // A vector along the z axis has no heading.
    a_axis_yaw: assert property (@(posedge clk) disable iff (!rst_n)
        (done && degenerate == dyp_pkg::DEG_AXIS) |-> (yaw == '0))
        else $error("vertical vector gave a nonzero yaw");

endmodule

`default_nettype wire
